@@ sv/thermal_palette_colormap_core_defines.svh @@
// ----------------------------------------------------------------------------
// thermal_palette_colormap_core_defines
// Assertion macros for the port-level checker of the colormap core.
// ----------------------------------------------------------------------------
`ifndef THERMAL_PALETTE_COLORMAP_CORE_DEFINES_SVH
`define THERMAL_PALETTE_COLORMAP_CORE_DEFINES_SVH

// concurrent assertion, off while reset is high
`define TPC_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// concurrent assertion that is also checked through reset
`define TPC_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ sv/tpc_pkg.sv @@
// ----------------------------------------------------------------------------
// tpc_pkg
// Shared constants and pipeline types of the thermal colormap core.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package tpc_pkg;

   localparam int SAMPLE_BITS     = 16;
   localparam int NORM_BITS       = 10;
   localparam int QUO_BITS        = NORM_BITS;
   localparam int NUMER_BITS      = SAMPLE_BITS + NORM_BITS;
   localparam int GAMMA_ENTRIES   = 1024;
   localparam int GAMMA_ADDR_BITS = $clog2(GAMMA_ENTRIES);
   localparam int COLOR_BITS      = 8;
   localparam int PAL_BITS        = 3;
   localparam int CSR_INDEX_BITS  = 2;
   localparam int CSR_DATA_BITS   = SAMPLE_BITS;
   localparam int DIV_STAGES      = QUO_BITS;

   localparam logic [NORM_BITS-1:0] NORM_MAX = '1;

   // configuration register indexes
   localparam logic [CSR_INDEX_BITS-1:0] CSR_MIN_VALUE      = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_MAX_VALUE      = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_PALETTE_SELECT = 2'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_GAMMA_ENABLE   = 2'd3;

   // palette codes
   localparam logic [PAL_BITS-1:0] PAL_GREY        = 3'd0;
   localparam logic [PAL_BITS-1:0] PAL_HOTNESS     = 3'd1;
   localparam logic [PAL_BITS-1:0] PAL_RAINBOW     = 3'd2;
   localparam logic [PAL_BITS-1:0] PAL_INV_RAINBOW = 3'd3;

   // request as taken from the input channel
   typedef struct packed {
      logic                       mode;
      logic [SAMPLE_BITS-1:0]     sample;
      logic                       eof;
      logic [GAMMA_ADDR_BITS-1:0] tidx;
      logic [NORM_BITS-1:0]       tval;
   } req_type;

   // sideband that rides along the scaling pipeline
   typedef struct packed {
      logic                       mode;
      logic                       eof;
      logic [GAMMA_ADDR_BITS-1:0] tidx;
      logic [NORM_BITS-1:0]       tval;
      logic                       zero;
      logic                       sat;
   } tag_type;

   // divider stage contents
   typedef struct packed {
      tag_type                tag;
      logic [NUMER_BITS-1:0]  rem;
      logic [SAMPLE_BITS-1:0] rng;
      logic [QUO_BITS-1:0]    quo;
   } div_type;

   // pixel entering the palette stage
   typedef struct packed {
      logic [NORM_BITS-1:0] n;
      logic [NORM_BITS-1:0] gdata;
      logic                 eof;
   } pix_type;

   typedef struct packed {
      logic [COLOR_BITS-1:0] r;
      logic [COLOR_BITS-1:0] g;
      logic [COLOR_BITS-1:0] b;
   } rgb_type;

endpackage

`default_nettype wire

@@ sv/tpc_norm.sv @@
// ----------------------------------------------------------------------------
// tpc_norm
// Front of the scaling pipeline: offset, range, times 1023 and saturation.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tpc_norm
   import tpc_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   in_valid,
   output logic                        in_ready,
   input  wire req_type                in_req,
   input  wire logic [SAMPLE_BITS-1:0] min_value,
   input  wire logic [SAMPLE_BITS-1:0] max_value,
   output logic                        out_valid,
   input  wire logic                   out_ready,
   output div_type                     out_item
);

   logic                   s1_v_ff, s2_v_ff, s3_v_ff;
   logic                   s1_rdy, s2_rdy, s3_rdy;
   tag_type                s1_tag_ff, s1_tag_in;
   logic [SAMPLE_BITS-1:0] s1_diff_ff, s1_diff_in;
   logic [SAMPLE_BITS-1:0] s1_rng_ff, s1_rng_in;
   tag_type                s2_tag_ff;
   logic [NUMER_BITS-1:0]  s2_numer_ff, s2_numer_in;
   logic [SAMPLE_BITS-1:0] s2_rng_ff;
   div_type                s3_item_ff, s3_item_in;

   assign s3_rdy   = !s3_v_ff || out_ready;
   assign s2_rdy   = !s2_v_ff || s3_rdy;
   assign s1_rdy   = !s1_v_ff || s2_rdy;
   assign in_ready = s1_rdy;

   // stage 1: offset from min and the divisor
   always_comb begin
      s1_tag_in.mode = in_req.mode;
      s1_tag_in.eof  = in_req.eof;
      s1_tag_in.tidx = in_req.tidx;
      s1_tag_in.tval = in_req.tval;
      s1_tag_in.zero = (in_req.sample <= min_value);
      s1_tag_in.sat  = 1'b0;
      s1_diff_in     = in_req.sample - min_value;
      s1_rng_in      = (max_value > min_value) ? (max_value - min_value)
                                               : SAMPLE_BITS'(1);
   end

   // stage 2: diff * 1023 as (diff << 10) - diff
   assign s2_numer_in = {s1_diff_ff, NORM_BITS'(0)} - NUMER_BITS'(s1_diff_ff);

   // stage 3: quotient would reach 1024 or more
   always_comb begin
      s3_item_in         = '0;
      s3_item_in.tag     = s2_tag_ff;
      s3_item_in.tag.sat = (s2_numer_ff >= {s2_rng_ff, NORM_BITS'(0)});
      s3_item_in.rem     = s2_numer_ff;
      s3_item_in.rng     = s2_rng_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
         s2_v_ff <= 1'b0;
         s3_v_ff <= 1'b0;
      end else begin
         if (s1_rdy) s1_v_ff <= in_valid;
         if (s2_rdy) s2_v_ff <= s1_v_ff;
         if (s3_rdy) s3_v_ff <= s2_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_rdy && in_valid) begin
         s1_tag_ff  <= s1_tag_in;
         s1_diff_ff <= s1_diff_in;
         s1_rng_ff  <= s1_rng_in;
      end
      if (s2_rdy && s1_v_ff) begin
         s2_tag_ff   <= s1_tag_ff;
         s2_numer_ff <= s2_numer_in;
         s2_rng_ff   <= s1_rng_ff;
      end
      if (s3_rdy && s2_v_ff) begin
         s3_item_ff <= s3_item_in;
      end
   end

   assign out_valid = s3_v_ff;
   assign out_item  = s3_item_ff;

endmodule

`default_nettype wire

@@ sv/tpc_div.sv @@
// ----------------------------------------------------------------------------
// tpc_div
// Restoring divider, one quotient bit per pipeline stage, MSB first.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tpc_div
   import tpc_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    in_valid,
   output logic         in_ready,
   input  wire div_type in_item,
   output logic         out_valid,
   input  wire logic    out_ready,
   output div_type      out_item
);

   // chain index j is the input of stage j; index DIV_STAGES is the output
   logic    c_v    [DIV_STAGES+1];
   logic    c_rdy  [DIV_STAGES+1];
   div_type c_item [DIV_STAGES+1];

   logic    v_ff    [DIV_STAGES];
   div_type item_ff [DIV_STAGES];

   assign c_v[0]            = in_valid;
   assign c_item[0]         = in_item;
   assign in_ready          = c_rdy[0];
   assign c_rdy[DIV_STAGES] = out_ready;
   assign out_valid         = c_v[DIV_STAGES];
   assign out_item          = c_item[DIV_STAGES];

   for (genvar j = 0; j < DIV_STAGES; j++) begin : g_stage
      logic [NUMER_BITS-1:0] shifted;
      logic                  ge;
      div_type               stage_in;

      // remainder stays below rng << (bit + 1) when no saturation
      assign shifted = NUMER_BITS'(c_item[j].rng) << (QUO_BITS - 1 - j);
      assign ge      = (c_item[j].rem >= shifted);

      always_comb begin
         stage_in = c_item[j];
         if (ge) begin
            stage_in.rem = c_item[j].rem - shifted;
            stage_in.quo = c_item[j].quo | (QUO_BITS'(1) << (QUO_BITS - 1 - j));
         end
      end

      assign c_rdy[j]    = !v_ff[j] || c_rdy[j+1];
      assign c_v[j+1]    = v_ff[j];
      assign c_item[j+1] = item_ff[j];

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[j] <= 1'b0;
         end else if (c_rdy[j]) begin
            v_ff[j] <= c_v[j];
         end
      end

      always_ff @(posedge clock) begin
         if (c_rdy[j] && c_v[j]) begin
            item_ff[j] <= stage_in;
         end
      end
   end

endmodule

`default_nettype wire

@@ sv/tpc_gamma.sv @@
// ----------------------------------------------------------------------------
// tpc_gamma
// Final normalized value and the gamma table: writes for table requests,
// registered reads for pixel requests, both in request order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tpc_gamma
   import tpc_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    in_valid,
   output logic         in_ready,
   input  wire div_type in_item,
   output logic         out_valid,
   input  wire logic    out_ready,
   output pix_type      out_pix
);

   logic [NORM_BITS-1:0] gamma_mem [GAMMA_ENTRIES];

   logic                 g_v_ff, p_v_ff;
   logic                 g_rdy, p_rdy, g_adv;
   logic [NORM_BITS-1:0] g_n_ff, g_n_in;
   tag_type              g_tag_ff;
   logic [NORM_BITS-1:0] p_n_ff;
   logic                 p_eof_ff;
   logic [NORM_BITS-1:0] gdata_ff;

   assign p_rdy    = !p_v_ff || out_ready;
   assign g_rdy    = !g_v_ff || p_rdy;
   assign g_adv    = g_v_ff && p_rdy;
   assign in_ready = g_rdy;

   always_comb begin
      if (in_item.tag.zero) begin
         g_n_in = '0;
      end else if (in_item.tag.sat) begin
         g_n_in = NORM_MAX;
      end else begin
         g_n_in = in_item.quo;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         g_v_ff <= 1'b0;
         p_v_ff <= 1'b0;
      end else begin
         if (g_rdy) g_v_ff <= in_valid;
         // table writes end here
         if (p_rdy) p_v_ff <= g_v_ff && !g_tag_ff.mode;
      end
   end

   always_ff @(posedge clock) begin
      if (g_rdy && in_valid) begin
         g_n_ff   <= g_n_in;
         g_tag_ff <= in_item.tag;
      end
      if (g_adv) begin
         p_n_ff   <= g_n_ff;
         p_eof_ff <= g_tag_ff.eof;
      end
   end

   always_ff @(posedge clock) begin
      if (g_adv) begin
         if (g_tag_ff.mode) begin
            gamma_mem[g_tag_ff.tidx] <= g_tag_ff.tval;
         end
         gdata_ff <= gamma_mem[g_n_ff];
      end
   end

   assign out_valid     = p_v_ff;
   assign out_pix.n     = p_n_ff;
   assign out_pix.gdata = gdata_ff;
   assign out_pix.eof   = p_eof_ff;

endmodule

`default_nettype wire

@@ sv/tpc_palette.sv @@
// ----------------------------------------------------------------------------
// tpc_palette
// Gamma select and palette lookup into the response register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tpc_palette
   import tpc_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                in_valid,
   output logic                     in_ready,
   input  wire pix_type             in_pix,
   input  wire logic [PAL_BITS-1:0] palette_select,
   input  wire logic                gamma_enable,
   output logic                     out_valid,
   input  wire logic                out_ready,
   output rgb_type                  out_rgb,
   output logic                     out_eof
);

   // red at zero through green to blue at full scale
   function automatic rgb_type hue_ramp(input logic [NORM_BITS-1:0] m);
      rgb_type               c;
      logic [COLOR_BITS-1:0] f;
      f = m[COLOR_BITS-1:0];
      case (m[NORM_BITS-1:COLOR_BITS])
         2'd0:    c = '{r: '1, g: f,  b: '0};
         2'd1:    c = '{r: ~f, g: '1, b: '0};
         2'd2:    c = '{r: '0, g: '1, b: f};
         default: c = '{r: '0, g: ~f, b: '1};
      endcase
      return c;
   endfunction

   logic                  o_v_ff;
   logic                  o_rdy;
   rgb_type               rgb_ff, rgb_in;
   logic                  eof_ff;
   logic [NORM_BITS-1:0]  n;
   logic [COLOR_BITS-1:0] f;

   assign o_rdy    = !o_v_ff || out_ready;
   assign in_ready = o_rdy;

   assign n = gamma_enable ? in_pix.gdata : in_pix.n;
   assign f = n[COLOR_BITS-1:0];

   always_comb begin
      case (palette_select)
         PAL_GREY: begin
            rgb_in.r = n[NORM_BITS-1:NORM_BITS-COLOR_BITS];
            rgb_in.g = n[NORM_BITS-1:NORM_BITS-COLOR_BITS];
            rgb_in.b = n[NORM_BITS-1:NORM_BITS-COLOR_BITS];
         end
         PAL_HOTNESS: begin
            case (n[NORM_BITS-1:COLOR_BITS])
               2'd0:    rgb_in = '{r: '0, g: '0, b: f};
               2'd1:    rgb_in = '{r: f,  g: '0, b: ~f};
               2'd2:    rgb_in = '{r: '1, g: f,  b: '0};
               default: rgb_in = '{r: '1, g: '1, b: f};
            endcase
         end
         PAL_RAINBOW:     rgb_in = hue_ramp(~n);  // 1023 - n
         PAL_INV_RAINBOW: rgb_in = hue_ramp(n);
         default:         rgb_in = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         o_v_ff <= 1'b0;
      end else if (o_rdy) begin
         o_v_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (o_rdy && in_valid) begin
         rgb_ff <= rgb_in;
         eof_ff <= in_pix.eof;
      end
   end

   assign out_valid = o_v_ff;
   assign out_rgb   = rgb_ff;
   assign out_eof   = eof_ff;

endmodule

`default_nettype wire

@@ sv/thermal_palette_colormap_core.sv @@
// Throughput: one request per cycle while rsp_stall is low; the ten-stage
// divider and the gamma table (a read on every request, plus a write for
// table requests) each take one. Table write requests make no
// response. Stalls back up stage by stage.
// Reset clears pipeline valids and the registers (max_value to 65535);
// the gamma table is not cleared and holds unknown data until written.
// ----------------------------------------------------------------------------
// thermal_palette_colormap_core
// Thermal sample to false-color RGB: scaling, gamma table and palettes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module thermal_palette_colormap_core
   import tpc_pkg::*;
(
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_valid,
   output logic                            req_stall,
   input  wire logic                       req_mode,
   input  wire logic [SAMPLE_BITS-1:0]     req_thermal_sample,
   input  wire logic                       req_end_of_frame,
   input  wire logic [GAMMA_ADDR_BITS-1:0] req_table_index,
   input  wire logic [NORM_BITS-1:0]       req_table_value,
   output logic                            rsp_valid,
   input  wire logic                       rsp_stall,
   output logic [COLOR_BITS-1:0]           rsp_red,
   output logic [COLOR_BITS-1:0]           rsp_green,
   output logic [COLOR_BITS-1:0]           rsp_blue,
   output logic                            rsp_frame_done,
   input  wire logic                       csr_write_enable,
   input  wire logic [CSR_INDEX_BITS-1:0]  csr_index,
   input  wire logic [CSR_DATA_BITS-1:0]   csr_write_data
);

   logic [SAMPLE_BITS-1:0] min_value_ff;
   logic [SAMPLE_BITS-1:0] max_value_ff;
   logic [PAL_BITS-1:0]    palette_select_ff;
   logic                   gamma_enable_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         min_value_ff      <= '0;
         max_value_ff      <= '1;
         palette_select_ff <= PAL_GREY;
         gamma_enable_ff   <= 1'b0;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_MIN_VALUE:      min_value_ff      <= csr_write_data;
            CSR_MAX_VALUE:      max_value_ff      <= csr_write_data;
            CSR_PALETTE_SELECT: palette_select_ff <= csr_write_data[PAL_BITS-1:0];
            CSR_GAMMA_ENABLE:   gamma_enable_ff   <= csr_write_data[0];
            default: ;
         endcase
      end
   end

   req_type req;
   logic    norm_ready;
   logic    nd_valid, nd_ready;
   div_type nd_item;
   logic    dg_valid, dg_ready;
   div_type dg_item;
   logic    gp_valid, gp_ready;
   pix_type gp_pix;
   rgb_type rgb;

   assign req.mode   = req_mode;
   assign req.sample = req_thermal_sample;
   assign req.eof    = req_end_of_frame;
   assign req.tidx   = req_table_index;
   assign req.tval   = req_table_value;
   assign req_stall  = !norm_ready;

   tpc_norm u_norm (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (norm_ready),
      .in_req    (req),
      .min_value (min_value_ff),
      .max_value (max_value_ff),
      .out_valid (nd_valid),
      .out_ready (nd_ready),
      .out_item  (nd_item)
   );

   tpc_div u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (nd_valid),
      .in_ready  (nd_ready),
      .in_item   (nd_item),
      .out_valid (dg_valid),
      .out_ready (dg_ready),
      .out_item  (dg_item)
   );

   tpc_gamma u_gamma (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (dg_valid),
      .in_ready  (dg_ready),
      .in_item   (dg_item),
      .out_valid (gp_valid),
      .out_ready (gp_ready),
      .out_pix   (gp_pix)
   );

   tpc_palette u_palette (
      .clock          (clock),
      .reset          (reset),
      .in_valid       (gp_valid),
      .in_ready       (gp_ready),
      .in_pix         (gp_pix),
      .palette_select (palette_select_ff),
      .gamma_enable   (gamma_enable_ff),
      .out_valid      (rsp_valid),
      .out_ready      (!rsp_stall),
      .out_rgb        (rgb),
      .out_eof        (rsp_frame_done)
   );

   assign rsp_red   = rgb.r;
   assign rsp_green = rgb.g;
   assign rsp_blue  = rgb.b;

endmodule

`default_nettype wire

@@ sv/tpc_checker.sv @@
// ----------------------------------------------------------------------------
// tpc_checker
// Port-level checks of the colormap core, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "thermal_palette_colormap_core_defines.svh"

module tpc_checker
   import tpc_pkg::*;
(
   input wire logic                  clock,
   input wire logic                  reset,
   input wire logic                  req_valid,
   input wire logic                  req_stall,
   input wire logic                  rsp_valid,
   input wire logic                  rsp_stall,
   input wire logic [COLOR_BITS-1:0] rsp_red,
   input wire logic [COLOR_BITS-1:0] rsp_green,
   input wire logic [COLOR_BITS-1:0] rsp_blue,
   input wire logic                  rsp_frame_done
);

   // a held response keeps its payload
   `TPC_ASSERT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall |=> rsp_valid && $stable({rsp_red, rsp_green, rsp_blue, rsp_frame_done}), "response changed while stalled")

   // pipeline is empty right after reset
   `TPC_ASSERT_ALWAYS(a_rsp_empty_after_reset, clock, $past(reset) |-> !rsp_valid, "response valid right after reset")

   // a response cannot cross the pipeline straight out of reset
   `TPC_ASSERT_ALWAYS(a_rsp_min_latency, clock, $past(reset, 2) |-> !rsp_valid, "response too soon after reset")

   // an empty pipeline takes requests
   `TPC_ASSERT_ALWAYS(a_req_ready_after_reset, clock, $past(reset) |-> !req_stall, "request stalled on empty pipeline")

   // a request just after reset has ended is not stalled, whatever rsp_stall does
   `TPC_ASSERT(a_req_flow, clock, reset, $past(reset, 2) && !$past(reset) && req_valid |-> !req_stall, "request stalled one cycle after reset")

endmodule

bind thermal_palette_colormap_core tpc_checker u_tpc_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_valid),
   .req_stall      (req_stall),
   .rsp_valid      (rsp_valid),
   .rsp_stall      (rsp_stall),
   .rsp_red        (rsp_red),
   .rsp_green      (rsp_green),
   .rsp_blue       (rsp_blue),
   .rsp_frame_done (rsp_frame_done)
);

`default_nettype wire

@@ test/thermal_palette_colormap_core_checker.sv @@
// ----------------------------------------------------------------------------
// thermal_palette_colormap_core_checker
// Watches the request, response and register ports of the colormap core,
// keeps its own copy of the registers and the gamma table, predicts the
// color of every pixel request and compares it with the response stream.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module thermal_palette_colormap_core_checker
   import tpc_pkg::*;
#(
   parameter logic TABLE_MODE = 1'b1
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_valid,
   input  wire logic                       req_stall,
   input  wire logic                       req_mode,
   input  wire logic [SAMPLE_BITS-1:0]     req_thermal_sample,
   input  wire logic                       req_end_of_frame,
   input  wire logic [GAMMA_ADDR_BITS-1:0] req_table_index,
   input  wire logic [NORM_BITS-1:0]       req_table_value,
   input  wire logic                       rsp_valid,
   input  wire logic                       rsp_stall,
   input  wire logic [COLOR_BITS-1:0]      rsp_red,
   input  wire logic [COLOR_BITS-1:0]      rsp_green,
   input  wire logic [COLOR_BITS-1:0]      rsp_blue,
   input  wire logic                       rsp_frame_done,
   input  wire logic                       csr_write_enable,
   input  wire logic [CSR_INDEX_BITS-1:0]  csr_index,
   input  wire logic [CSR_DATA_BITS-1:0]   csr_write_data,
   output int                              mismatch_count,
   output int                              pixels_due
);

   typedef struct packed {
      rgb_type rgb;
      logic    frame_done;
   } pixel_type;

   logic [SAMPLE_BITS-1:0] lo_value;
   logic [SAMPLE_BITS-1:0] hi_value;
   logic [PAL_BITS-1:0]    palette;
   logic                   gamma_on;
   logic [NORM_BITS-1:0]   gamma_copy [GAMMA_ENTRIES];
   pixel_type              colors_due [$];
   int                     fails = 0;

   // truncating divide, clamped to the 10-bit scale
   function automatic logic [NORM_BITS-1:0] scale_sample(logic [SAMPLE_BITS-1:0] sample);
      logic [31:0] span;
      logic [31:0] quo;
      if (sample <= lo_value) return '0;
      span = (hi_value > lo_value) ? 32'(hi_value - lo_value) : 32'd1;
      quo = (32'(sample - lo_value) * 32'(NORM_MAX)) / span;
      return (quo > 32'(NORM_MAX)) ? NORM_MAX : quo[NORM_BITS-1:0];
   endfunction

   // red at 0 up to blue at 1023, four 256-wide segments
   function automatic rgb_type spectrum(logic [NORM_BITS-1:0] n);
      logic [COLOR_BITS-1:0] f;
      rgb_type c;
      f = n[7:0];
      case (n[9:8])
         2'd0: c = '{r: 8'd255, g: f, b: 8'd0};
         2'd1: c = '{r: 8'd255 - f, g: 8'd255, b: 8'd0};
         2'd2: c = '{r: 8'd0, g: 8'd255, b: f};
         default: c = '{r: 8'd0, g: 8'd255 - f, b: 8'd255};
      endcase
      return c;
   endfunction

   function automatic pixel_type map_pixel(logic [SAMPLE_BITS-1:0] sample, logic eof);
      logic [NORM_BITS-1:0]  n;
      logic [COLOR_BITS-1:0] f;
      pixel_type p;
      n = scale_sample(sample);
      if (gamma_on) n = gamma_copy[n];
      f = n[7:0];
      case (palette)
         PAL_GREY: p.rgb = '{r: n[9:2], g: n[9:2], b: n[9:2]};
         PAL_HOTNESS: begin
            case (n[9:8])
               2'd0: p.rgb = '{r: 8'd0, g: 8'd0, b: f};
               2'd1: p.rgb = '{r: f, g: 8'd0, b: 8'd255 - f};
               2'd2: p.rgb = '{r: 8'd255, g: f, b: 8'd0};
               default: p.rgb = '{r: 8'd255, g: 8'd255, b: f};
            endcase
         end
         PAL_RAINBOW: p.rgb = spectrum(NORM_MAX - n);
         PAL_INV_RAINBOW: p.rgb = spectrum(n);
         default: p.rgb = '0;
      endcase
      p.frame_done = eof;
      return p;
   endfunction

   always @(posedge clock) begin
      pixel_type seen;
      pixel_type want;
      if (reset) begin
         lo_value = '0;
         hi_value = '1;
         palette = PAL_GREY;
         gamma_on = 1'b0;
         colors_due.delete();
      end else begin
         if (csr_write_enable) begin
            case (csr_index)
               CSR_MIN_VALUE: lo_value = csr_write_data;
               CSR_MAX_VALUE: hi_value = csr_write_data;
               CSR_PALETTE_SELECT: palette = csr_write_data[PAL_BITS-1:0];
               CSR_GAMMA_ENABLE: gamma_on = csr_write_data[0];
               default: ;
            endcase
         end
         if (req_valid && !req_stall) begin
            if (req_mode == TABLE_MODE)
               gamma_copy[req_table_index] = req_table_value;
            else
               colors_due.push_back(map_pixel(req_thermal_sample, req_end_of_frame));
         end
         if (rsp_valid && !rsp_stall) begin
            seen = '{rgb: '{r: rsp_red, g: rsp_green, b: rsp_blue},
                     frame_done: rsp_frame_done};
            if (colors_due.size() == 0) begin
               $error("response with no pixel request outstanding: r %0d g %0d b %0d",
                      rsp_red, rsp_green, rsp_blue);
               fails++;
            end else begin
               want = colors_due.pop_front();
               if (seen.rgb.r !== want.rgb.r) begin
                  $error("red: expected %0d, got %0d", want.rgb.r, seen.rgb.r);
                  fails++;
               end
               if (seen.rgb.g !== want.rgb.g) begin
                  $error("green: expected %0d, got %0d", want.rgb.g, seen.rgb.g);
                  fails++;
               end
               if (seen.rgb.b !== want.rgb.b) begin
                  $error("blue: expected %0d, got %0d", want.rgb.b, seen.rgb.b);
                  fails++;
               end
               if (seen.frame_done !== want.frame_done) begin
                  $error("frame_done: expected %0d, got %0d",
                         want.frame_done, seen.frame_done);
                  fails++;
               end
            end
         end
      end
      mismatch_count <= fails;
      pixels_due <= colors_due.size();
   end

endmodule

@@ test/thermal_palette_colormap_core_test.sv @@
// ----------------------------------------------------------------------------
// thermal_palette_colormap_core_test
// Stimulus for the colormap core: loads the whole gamma table, runs directed
// pixels over every palette and range corner, then random register settings
// with mixed pixel and table requests under random gaps and back-pressure.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module thermal_palette_colormap_core_test;
   import tpc_pkg::*;

   localparam logic MODE_PIXEL = 1'b0;
   localparam logic MODE_TABLE = 1'b1;
   localparam logic [PAL_BITS-1:0] PAL_BLACK_FIRST = 3'd4;
   localparam logic [PAL_BITS-1:0] PAL_BLACK_LAST  = 3'd7;
   localparam int RANDOM_REQUESTS = 450;
   localparam int SETTLE_CYCLES   = 24;
   localparam int LONG_HOLD       = 300;
   localparam int CYCLE_LIMIT     = 600000;

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       req_valid = 1'b0;
   logic                       req_stall;
   logic                       req_mode = MODE_PIXEL;
   logic [SAMPLE_BITS-1:0]     req_thermal_sample = '0;
   logic                       req_end_of_frame = 1'b0;
   logic [GAMMA_ADDR_BITS-1:0] req_table_index = '0;
   logic [NORM_BITS-1:0]       req_table_value = '0;
   logic                       rsp_valid;
   logic                       rsp_stall = 1'b0;
   logic [COLOR_BITS-1:0]      rsp_red;
   logic [COLOR_BITS-1:0]      rsp_green;
   logic [COLOR_BITS-1:0]      rsp_blue;
   logic                       rsp_frame_done;
   logic                       csr_write_enable = 1'b0;
   logic [CSR_INDEX_BITS-1:0]  csr_index = CSR_MIN_VALUE;
   logic [CSR_DATA_BITS-1:0]   csr_write_data = '0;

   int mismatch_count;
   int pixels_due;
   int cycles = 0;
   int holds_wanted = 0;
   int holds_done = 0;
   bit quiet_phase = 1'b0;
   logic [SAMPLE_BITS-1:0] lo_cfg = '0;
   logic [SAMPLE_BITS-1:0] hi_cfg = '1;

   thermal_palette_colormap_core dut (.*);

   thermal_palette_colormap_core_checker #(.TABLE_MODE(MODE_TABLE)) color_check (.*);

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("[thermal_palette_colormap_core] ERROR");
      $finish;
   end

   // response side: random stall before each response, plus long hold-offs
   initial begin
      int hold;
      @(posedge clock);
      forever begin
         if (holds_done != holds_wanted) begin
            holds_done++;
            hold = LONG_HOLD;
         end else begin
            hold = quiet_phase ? 0 : $urandom_range(0, 8);
         end
         if (hold != 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (rsp_valid !== 1'b1 || rsp_stall);
      end
   end

   task automatic send_request(logic mode, logic [SAMPLE_BITS-1:0] sample, logic eof,
                               logic [GAMMA_ADDR_BITS-1:0] tidx, logic [NORM_BITS-1:0] tval);
      int gap;
      gap = quiet_phase ? 0 : $urandom_range(0, 8);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_mode <= mode;
      req_thermal_sample <= sample;
      req_end_of_frame <= eof;
      req_table_index <= tidx;
      req_table_value <= tval;
      do @(posedge clock); while (req_stall !== 1'b0);
   endtask

   task automatic send_pixel(logic [SAMPLE_BITS-1:0] sample, logic eof);
      send_request(MODE_PIXEL, sample, eof, GAMMA_ADDR_BITS'($urandom),
                   NORM_BITS'($urandom));
   endtask

   task automatic send_entry(logic [GAMMA_ADDR_BITS-1:0] tidx, logic [NORM_BITS-1:0] tval);
      send_request(MODE_TABLE, SAMPLE_BITS'($urandom), 1'($urandom), tidx, tval);
   endtask

   // drop valid and wait until every pixel has come back and the pipe is empty
   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pixels_due != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic configure(logic [SAMPLE_BITS-1:0] lo, logic [SAMPLE_BITS-1:0] hi,
                            logic [PAL_BITS-1:0] pal, logic gamma);
      settle();
      csr_write_enable <= 1'b1;
      csr_index <= CSR_MIN_VALUE;
      csr_write_data <= lo;
      @(posedge clock);
      csr_index <= CSR_MAX_VALUE;
      csr_write_data <= hi;
      @(posedge clock);
      // unused upper data bits carry noise
      csr_index <= CSR_PALETTE_SELECT;
      csr_write_data <= {(CSR_DATA_BITS - PAL_BITS)'($urandom), pal};
      @(posedge clock);
      csr_index <= CSR_GAMMA_ENABLE;
      csr_write_data <= {(CSR_DATA_BITS - 1)'($urandom), gamma};
      @(posedge clock);
      csr_write_enable <= 1'b0;
      lo_cfg = lo;
      hi_cfg = hi;
   endtask

   function automatic logic [SAMPLE_BITS-1:0] pick_sample();
      case ($urandom_range(0, 7))
         0: return SAMPLE_BITS'($urandom);
         1: return $urandom_range(0, 1) ? '1 : '0;
         2: return SAMPLE_BITS'(lo_cfg + $urandom_range(0, 4) - 2);
         3: return SAMPLE_BITS'(hi_cfg + $urandom_range(0, 4) - 2);
         default: return SAMPLE_BITS'($urandom_range(lo_cfg, hi_cfg));
      endcase
   endfunction

   initial begin
      int sent;
      int phase;
      int span;
      logic [SAMPLE_BITS-1:0] lo;
      logic [SAMPLE_BITS-1:0] hi;
      logic [PAL_BITS-1:0] pal;

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // fill the whole gamma table first so no gamma read hits an empty entry
      for (int i = 0; i < GAMMA_ENTRIES; i++)
         send_entry(GAMMA_ADDR_BITS'(i), NORM_BITS'($urandom));

      // full scale grey
      configure('0, '1, PAL_GREY, 1'b0);
      send_pixel(16'h0000, 1'b0);
      send_pixel(16'hFFFF, 1'b1);
      send_pixel(16'h0001, 1'b0);
      send_pixel(16'h8000, 1'b1);

      // hotness: below, at min, at max, above max, one per quarter
      configure(16'd1000, 16'd3000, PAL_HOTNESS, 1'b0);
      send_pixel(16'd999, 1'b0);
      send_pixel(16'd1000, 1'b0);
      send_pixel(16'd3000, 1'b0);
      send_pixel(16'd5000, 1'b1);
      send_pixel(16'd1300, 1'b0);
      send_pixel(16'd1800, 1'b0);
      send_pixel(16'd2500, 1'b1);

      // inverted range: anything above min goes full scale
      configure(16'd4000, 16'd100, PAL_RAINBOW, 1'b0);
      send_pixel(16'd4000, 1'b0);
      send_pixel(16'd4001, 1'b1);
      send_pixel(16'd0, 1'b0);

      // one-to-one scale, inverse rainbow through every segment to pure blue
      configure(16'd0, 16'd1023, PAL_INV_RAINBOW, 1'b0);
      send_pixel(16'd100, 1'b0);
      send_pixel(16'd300, 1'b0);
      send_pixel(16'd600, 1'b0);
      send_pixel(16'd1023, 1'b1);

      configure(16'd0, 16'd1023, PAL_BLACK_LAST, 1'b1);
      send_pixel(16'd500, 1'b1);

      // gamma lookup at both table ends after rewriting them
      configure(16'd0, 16'd1023, PAL_GREY, 1'b1);
      send_entry('1, '0);
      send_entry('0, '1);
      send_pixel(16'd1023, 1'b0);
      send_pixel(16'd0, 1'b0);
      send_pixel(16'd512, 1'b1);

      sent = 0;
      phase = 0;
      while (sent < RANDOM_REQUESTS) begin
         case ($urandom_range(0, 5))
            0: begin lo = '0; hi = '1; end
            1: begin lo = SAMPLE_BITS'($urandom); hi = SAMPLE_BITS'($urandom); end
            2: begin
               lo = SAMPLE_BITS'($urandom_range(0, 60000));
               hi = lo + SAMPLE_BITS'($urandom_range(1, 2000));
            end
            3: begin lo = SAMPLE_BITS'($urandom); hi = lo; end
            4: begin lo = '1; hi = $urandom_range(0, 1) ? '1 : '0; end
            default: begin
               lo = SAMPLE_BITS'($urandom_range(0, 1000));
               hi = lo + SAMPLE_BITS'(1023);
            end
         endcase
         if ($urandom_range(0, 4) == 0)
            pal = PAL_BITS'($urandom_range(PAL_BLACK_FIRST, PAL_BLACK_LAST));
         else
            pal = PAL_BITS'($urandom_range(PAL_GREY, PAL_INV_RAINBOW));
         configure(lo, hi, pal, 1'($urandom));

         quiet_phase = ($urandom_range(0, 3) == 0);
         span = $urandom_range(20, 120);
         // long output hold-off so the pipe backs up into req_stall
         if (phase == 1 || phase == 9) begin
            quiet_phase = 1'b1;
            holds_wanted++;
            span = 120;
         end
         repeat (span) begin
            if ($urandom_range(0, 6) == 0)
               send_entry(GAMMA_ADDR_BITS'($urandom), NORM_BITS'($urandom));
            else
               send_pixel(pick_sample(), $urandom_range(0, 15) == 0);
            sent++;
         end
         phase++;
      end

      quiet_phase = 1'b0;
      settle();
      if (mismatch_count == 0)
         $display("[thermal_palette_colormap_core] OK");
      else
         $display("[thermal_palette_colormap_core] ERROR");
      $finish;
   end

endmodule

@@ files.f @@
+incdir+sv
sv/tpc_pkg.sv
sv/tpc_norm.sv
sv/tpc_div.sv
sv/tpc_gamma.sv
sv/tpc_palette.sv
sv/thermal_palette_colormap_core.sv
sv/tpc_checker.sv
test/thermal_palette_colormap_core_checker.sv
test/thermal_palette_colormap_core_test.sv
